FILE: design/tcr_pkg.sv
// shared types and constants for the triangle coverage rasterizer
// no dependencies; used by every other design file except tcr_ram
`default_nettype none

package tcr_pkg;

    // field widths fixed by the interface
    localparam int CFG_W   = 9;   // image size register
    localparam int VTX_W   = 16;  // Q2.14 vertex coordinate
    localparam int PIX_W   = 8;   // read column / row
    localparam int CNT_W   = 17;  // covered pixel count
    localparam int CIDX_W  = 4;   // config register index

    // internal arithmetic widths
    localparam int SCR_W   = 19;  // Q10.8 screen coordinate, signed
    localparam int OPD_W   = 21;  // multiplier operand, signed
    localparam int PRD_W   = 42;  // multiplier product, signed
    localparam int EDG_W   = 44;  // edge function accumulator, signed
    localparam int IDX_W   = 12;  // sample column / row counter
    localparam int STEP_W  = 4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ACTIVE_W = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_ACTIVE_H = 4'd1;

    // command codes
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // setup steps through the shared multiplier
    localparam logic [STEP_W-1:0] STEP_AX  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_AY  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_BX  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_BY  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CX  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CY  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_AR0 = 4'd6;
    localparam logic [STEP_W-1:0] STEP_AR1 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EA0 = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EA1 = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EB0 = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EB1 = 4'd11;
    localparam logic [STEP_W-1:0] STEP_EC0 = 4'd12;
    localparam logic [STEP_W-1:0] STEP_EC1 = 4'd13;

    typedef struct packed {
        logic                clr_en;    // clearing pass write
        logic                load;      // capture accepted word
        logic                mul_en;    // issue setup product
        logic                wb_en;     // write back setup product
        logic [STEP_W-1:0]   step;
        logic                box_en;    // bounding box and walk start
        logic                walk_en;   // visit one sample or turn column
        logic                fin_load;  // load result register
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic area_zero;
        logic walk_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: design/tcr_intf.sv
// channel interfaces: command input, result output, configuration write
// depends on tcr_pkg for field widths
`default_nettype none

interface tcr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic signed [tcr_pkg::VTX_W-1:0]       vertex_a_x;
    logic signed [tcr_pkg::VTX_W-1:0]       vertex_a_y;
    logic signed [tcr_pkg::VTX_W-1:0]       vertex_b_x;
    logic signed [tcr_pkg::VTX_W-1:0]       vertex_b_y;
    logic signed [tcr_pkg::VTX_W-1:0]       vertex_c_x;
    logic signed [tcr_pkg::VTX_W-1:0]       vertex_c_y;
    logic        [tcr_pkg::PIX_W-1:0]       read_column;
    logic        [tcr_pkg::PIX_W-1:0]       read_row;

    modport source (output valid, command, vertex_a_x, vertex_a_y, vertex_b_x,
                    vertex_b_y, vertex_c_x, vertex_c_y, read_column, read_row,
                    input ready);
    modport sink (input valid, command, vertex_a_x, vertex_a_y, vertex_b_x,
                  vertex_b_y, vertex_c_x, vertex_c_y, read_column, read_row,
                  output ready);
endinterface

interface tcr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          pixel_lit;
    logic [tcr_pkg::CNT_W-1:0]     pixels_covered;

    modport source (output valid, pixel_lit, pixels_covered, input ready);
    modport sink (input valid, pixel_lit, pixels_covered, output ready);
endinterface

interface tcr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcr_pkg::CIDX_W-1:0]    index;
    logic [tcr_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/tcr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tcr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/tcr_datapath.sv
// datapath: vertex mapping, shared setup multiplier, edge walkers,
// coverage ram and result register; depends on tcr_pkg and tcr_ram
`default_nettype none

module tcr_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tcr_pkg::t_ctl_cmd                 i_cmd,
    output tcr_pkg::t_dp_stat                      o_stat,
    input  wire logic [tcr_pkg::CFG_W-1:0]         i_img_w,
    input  wire logic [tcr_pkg::CFG_W-1:0]         i_img_h,
    input  wire logic                              i_command,
    input  wire logic signed [tcr_pkg::VTX_W-1:0]  i_ax,
    input  wire logic signed [tcr_pkg::VTX_W-1:0]  i_ay,
    input  wire logic signed [tcr_pkg::VTX_W-1:0]  i_bx,
    input  wire logic signed [tcr_pkg::VTX_W-1:0]  i_by,
    input  wire logic signed [tcr_pkg::VTX_W-1:0]  i_cx,
    input  wire logic signed [tcr_pkg::VTX_W-1:0]  i_cy,
    input  wire logic [tcr_pkg::PIX_W-1:0]         i_col,
    input  wire logic [tcr_pkg::PIX_W-1:0]         i_row,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_pixel_lit,
    output logic [tcr_pkg::CNT_W-1:0]              o_pixels_covered
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = 13;
    localparam int SW    = tcr_pkg::SCR_W;
    localparam int OW    = tcr_pkg::OPD_W;
    localparam int PW    = tcr_pkg::PRD_W;
    localparam int EW    = tcr_pkg::EDG_W;
    localparam int IW    = tcr_pkg::IDX_W;
    localparam int NW    = tcr_pkg::CNT_W;

    // active image size, saturated to 1..MAX
    logic [tcr_pkg::CFG_W-1:0] w_act, h_act;
    logic [tcr_pkg::CFG_W-2:0] hw, hh, h_sel;

    always_comb begin
        if (i_img_w == '0) begin
            w_act = tcr_pkg::CFG_W'(1);
        end else if (CMP_W'(i_img_w) > CMP_W'(MAX_WIDTH)) begin
            w_act = tcr_pkg::CFG_W'(MAX_WIDTH);
        end else begin
            w_act = i_img_w;
        end
        if (i_img_h == '0) begin
            h_act = tcr_pkg::CFG_W'(1);
        end else if (CMP_W'(i_img_h) > CMP_W'(MAX_HEIGHT)) begin
            h_act = tcr_pkg::CFG_W'(MAX_HEIGHT);
        end else begin
            h_act = i_img_h;
        end
    end

    assign hw = w_act[tcr_pkg::CFG_W-1:1];
    assign hh = h_act[tcr_pkg::CFG_W-1:1];

    // captured command word
    logic                             r_cmd;
    logic signed [tcr_pkg::VTX_W-1:0] r_vax, r_vay, r_vbx, r_vby, r_vcx, r_vcy;
    logic [tcr_pkg::PIX_W-1:0]        r_col, r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_vax <= i_ax;
            r_vay <= i_ay;
            r_vbx <= i_bx;
            r_vby <= i_by;
            r_vcx <= i_cx;
            r_vcy <= i_cy;
            r_col <= i_col;
            r_row <= i_row;
        end
    end

    // screen coordinates and box
    logic signed [SW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [SW-1:0] r_xmax, r_ymax;
    logic [IW-1:0]        r_x0, r_y0;
    logic signed [OW-1:0] px0, py0;

    assign px0 = $signed({1'b0, r_x0, 8'b0});
    assign py0 = $signed({1'b0, r_y0, 8'b0});

    // shared multiplier
    logic signed [OW-1:0] opa, opb;
    logic signed [PW-1:0] r_prod;

    always_comb begin
        opa = '0;
        opb = '0;
        case (i_cmd.step)
            tcr_pkg::STEP_AX: begin
                opa = OW'($signed({1'b0, hw}));
                opb = OW'(r_vax);
            end
            tcr_pkg::STEP_AY: begin
                opa = OW'($signed({1'b0, hh}));
                opb = OW'(r_vay);
            end
            tcr_pkg::STEP_BX: begin
                opa = OW'($signed({1'b0, hw}));
                opb = OW'(r_vbx);
            end
            tcr_pkg::STEP_BY: begin
                opa = OW'($signed({1'b0, hh}));
                opb = OW'(r_vby);
            end
            tcr_pkg::STEP_CX: begin
                opa = OW'($signed({1'b0, hw}));
                opb = OW'(r_vcx);
            end
            tcr_pkg::STEP_CY: begin
                opa = OW'($signed({1'b0, hh}));
                opb = OW'(r_vcy);
            end
            tcr_pkg::STEP_AR0: begin
                opa = OW'(r_bx) - OW'(r_ax);
                opb = OW'(r_cy) - OW'(r_ay);
            end
            tcr_pkg::STEP_AR1: begin
                opa = OW'(r_cx) - OW'(r_ax);
                opb = OW'(r_by) - OW'(r_ay);
            end
            tcr_pkg::STEP_EA0: begin
                opa = OW'(r_cx) - OW'(r_bx);
                opb = py0 - OW'(r_by);
            end
            tcr_pkg::STEP_EA1: begin
                opa = px0 - OW'(r_bx);
                opb = OW'(r_cy) - OW'(r_by);
            end
            tcr_pkg::STEP_EB0: begin
                opa = OW'(r_ax) - OW'(r_cx);
                opb = py0 - OW'(r_cy);
            end
            tcr_pkg::STEP_EB1: begin
                opa = px0 - OW'(r_cx);
                opb = OW'(r_ay) - OW'(r_cy);
            end
            tcr_pkg::STEP_EC0: begin
                opa = OW'(r_bx) - OW'(r_ax);
                opb = py0 - OW'(r_ay);
            end
            tcr_pkg::STEP_EC1: begin
                opa = px0 - OW'(r_ax);
                opb = OW'(r_by) - OW'(r_ay);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= opa * opb;
        end
    end

    // q2.14 to q10.8: floor(h*v/64) + 256h - 128
    logic signed [PW-1:0] scr_full;
    logic signed [SW-1:0] scr;

    assign h_sel    = i_cmd.step[0] ? hh : hw;
    assign scr_full = (r_prod >>> 6) + PW'($signed({1'b0, h_sel, 8'b0})) - PW'(128);
    assign scr      = $signed(scr_full[SW-1:0]);

    // box from the mapped vertices
    logic signed [SW-1:0] minx, miny, maxx, maxy, fminx, fminy;

    always_comb begin
        minx = (r_ax < r_bx) ? r_ax : r_bx;
        minx = (minx < r_cx) ? minx : r_cx;
        miny = (r_ay < r_by) ? r_ay : r_by;
        miny = (miny < r_cy) ? miny : r_cy;
        maxx = (r_ax > r_bx) ? r_ax : r_bx;
        maxx = (maxx > r_cx) ? maxx : r_cx;
        maxy = (r_ay > r_by) ? r_ay : r_by;
        maxy = (maxy > r_cy) ? maxy : r_cy;
        fminx = minx >>> 8;
        fminy = miny >>> 8;
    end

    // edge accumulators and walk counters
    logic signed [EW-1:0] r_tmp, r_area;
    logic signed [EW-1:0] r_ea, r_eb, r_ec, r_ca, r_cb, r_cc;
    logic [IW-1:0]        r_i, r_j;
    logic [NW-1:0]        r_cnt;

    logic signed [EW-1:0] row_a, row_b, row_c, col_a, col_b, col_c;
    logic signed [EW-1:0] prod_e;

    assign prod_e = EW'(r_prod);
    assign row_a  = (EW'(r_cx) - EW'(r_bx)) <<< 8;
    assign row_b  = (EW'(r_ax) - EW'(r_cx)) <<< 8;
    assign row_c  = (EW'(r_bx) - EW'(r_ax)) <<< 8;
    assign col_a  = (EW'(r_by) - EW'(r_cy)) <<< 8;
    assign col_b  = (EW'(r_cy) - EW'(r_ay)) <<< 8;
    assign col_c  = (EW'(r_ay) - EW'(r_by)) <<< 8;

    logic col_ok, row_ok, in_tri, ge0, le0;

    assign col_ok = (r_i < IW'(w_act)) &&
                    ($signed({1'b0, r_i, 8'b0}) < OW'(r_xmax));
    assign row_ok = (r_j < IW'(h_act)) &&
                    ($signed({1'b0, r_j, 8'b0}) < OW'(r_ymax));
    assign ge0    = !r_ea[EW-1] && !r_eb[EW-1] && !r_ec[EW-1];
    assign le0    = (r_ea[EW-1] || r_ea == '0) && (r_eb[EW-1] || r_eb == '0) &&
                    (r_ec[EW-1] || r_ec == '0);
    assign in_tri = r_area[EW-1] ? le0 : ge0;

    logic sample_hit;
    assign sample_hit = i_cmd.walk_en && col_ok && row_ok && in_tri;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt  <= '0;
            r_area <= '0;
        end
        if (i_cmd.wb_en) begin
            case (i_cmd.step)
                tcr_pkg::STEP_AX:  r_ax <= scr;
                tcr_pkg::STEP_AY:  r_ay <= scr;
                tcr_pkg::STEP_BX:  r_bx <= scr;
                tcr_pkg::STEP_BY:  r_by <= scr;
                tcr_pkg::STEP_CX:  r_cx <= scr;
                tcr_pkg::STEP_CY:  r_cy <= scr;
                tcr_pkg::STEP_AR1: r_area <= r_tmp - prod_e;
                tcr_pkg::STEP_EA1: begin
                    r_ea <= r_tmp - prod_e;
                    r_ca <= r_tmp - prod_e;
                end
                tcr_pkg::STEP_EB1: begin
                    r_eb <= r_tmp - prod_e;
                    r_cb <= r_tmp - prod_e;
                end
                tcr_pkg::STEP_EC1: begin
                    r_ec <= r_tmp - prod_e;
                    r_cc <= r_tmp - prod_e;
                end
                default: r_tmp <= prod_e;
            endcase
        end
        if (i_cmd.box_en) begin
            r_x0   <= fminx[SW-1] ? '0 : IW'(fminx);
            r_y0   <= fminy[SW-1] ? '0 : IW'(fminy);
            r_i    <= fminx[SW-1] ? '0 : IW'(fminx);
            r_j    <= fminy[SW-1] ? '0 : IW'(fminy);
            r_xmax <= maxx;
            r_ymax <= maxy;
        end
        if (i_cmd.walk_en && col_ok) begin
            if (row_ok) begin
                r_j  <= r_j + IW'(1);
                r_ea <= r_ea + row_a;
                r_eb <= r_eb + row_b;
                r_ec <= r_ec + row_c;
                if (in_tri) begin
                    r_cnt <= r_cnt + NW'(1);
                end
            end else begin
                // next column, back to the top row of the box
                r_i  <= r_i + IW'(1);
                r_j  <= r_y0;
                r_ea <= r_ca + col_a;
                r_eb <= r_cb + col_b;
                r_ec <= r_cc + col_c;
                r_ca <= r_ca + col_a;
                r_cb <= r_cb + col_b;
                r_cc <= r_cc + col_c;
            end
        end
    end

    // coverage ram: clearing pass after reset, then walk writes
    logic [AW-1:0] r_clr;
    logic [AW-1:0] waddr, raddr;
    logic          rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    assign waddr = i_cmd.clr_en ? r_clr
                 : AW'(AW'(r_j) * AW'(MAX_WIDTH) + AW'(r_i));
    assign raddr = AW'(AW'(r_row) * AW'(MAX_WIDTH) + AW'(r_col));

    tcr_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_en || sample_hit),
        .i_waddr (waddr),
        .i_wdata (!i_cmd.clr_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result register
    logic             r_out_valid, r_pix;
    logic [NW-1:0]    r_out_cnt;
    logic             rd_in_range;

    assign rd_in_range = (tcr_pkg::CFG_W'(r_col) < w_act) &&
                         (tcr_pkg::CFG_W'(r_row) < h_act);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_pix     <= (r_cmd == tcr_pkg::CMD_READ) && rdata && rd_in_range;
            r_out_cnt <= (r_cmd == tcr_pkg::CMD_READ) ? '0 : r_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_lit      = r_pix;
    assign o_pixels_covered = r_out_cnt;

    assign o_stat.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_stat.area_zero = (r_area == '0);
    assign o_stat.walk_done = !col_ok;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

FILE: design/tcr_ctrl.sv
// controller: sequences clearing pass, setup steps, walk and result hand-off
// depends on tcr_pkg
`default_nettype none

module tcr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_command,
    output logic                     o_in_ready,
    input  wire tcr_pkg::t_dp_stat   i_stat,
    output tcr_pkg::t_ctl_cmd        o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_WB    = 8'b0000_1000,
        S_BOX   = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [tcr_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_step  = tcr_pkg::STEP_AX;
                    n_state = (i_in_command == tcr_pkg::CMD_READ) ? S_READ : S_MUL;
                end
            end
            S_MUL: n_state = S_WB;
            S_WB: begin
                if (r_step == tcr_pkg::STEP_CY) begin
                    n_state = S_BOX;
                end else if (r_step == tcr_pkg::STEP_EC1) begin
                    n_state = i_stat.area_zero ? S_FIN : S_WALK;
                end else begin
                    n_state = S_MUL;
                end
                n_step = r_step + tcr_pkg::STEP_W'(1);
            end
            S_BOX:  n_state = S_MUL;
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_READ: n_state = S_FIN;
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_en   = (r_state == S_CLEAR);
        o_cmd.load     = accept;
        o_cmd.mul_en   = (r_state == S_MUL);
        o_cmd.wb_en    = (r_state == S_WB);
        o_cmd.step     = r_step;
        o_cmd.box_en   = (r_state == S_BOX);
        o_cmd.walk_en  = (r_state == S_WALK);
        o_cmd.fin_load = (r_state == S_FIN) && i_stat.out_free;
    end

    // the clearing pass ends straight into idle
    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_stat.clr_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end in idle");

    // a result is loaded only from the final state
    a_fin_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin_load |-> (r_state == S_FIN))
        else $error("result loaded outside final state");

    // a read never passes through setup
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_FIN))
        else $error("read did not go to final state");

endmodule

`default_nettype wire

FILE: design/triangle_coverage_rasterizer.sv
// top level of the triangle coverage rasterizer: config registers,
// controller and datapath; depends on tcr_pkg, tcr_intf, tcr_ctrl, tcr_datapath
//
// channels: i_in takes command words (draw a triangle or read one pixel),
// o_out returns one result word per command, i_cfg writes the active width
// (index 0) and active height (index 1); any other index is ignored. cfg is
// always ready.
// after reset the coverage ram is swept to black, one pixel a cycle, over all
// MAX_WIDTH*MAX_HEIGHT addresses (65536 at default size); i_in.ready stays low
// while the sweep runs, config writes are taken throughout.
// a read passes from accept through S_READ to S_FIN, which loads the result.
// a draw maps the vertices and sets up area and edge functions through one
// shared multiplier, each product issued in S_MUL and written back in S_WB:
// 14 products with the box step after the sixth, then the walk visits each box
// sample and turns at each box column, then S_FIN loads the result.
// a zero-area triangle skips the walk and reports 0 after setup.
// one command is in flight at a time; the result register holds a finished
// word while the receiver stalls and the next command is accepted meanwhile;
// its result waits in the final state until the register frees up.
`default_nettype none

module triangle_coverage_rasterizer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tcr_in_if.sink        i_in,
    tcr_out_if.source     o_out,
    tcr_cfg_if.sink       i_cfg
);

    // configuration registers, reset to 256 (full size when MAX is 256 or less)
    logic [tcr_pkg::CFG_W-1:0] r_img_w, r_img_h;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= tcr_pkg::CFG_W'(256);
            r_img_h <= tcr_pkg::CFG_W'(256);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tcr_pkg::CFG_ACTIVE_W: r_img_w <= i_cfg.data;
                tcr_pkg::CFG_ACTIVE_H: r_img_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    tcr_pkg::t_ctl_cmd cmd;
    tcr_pkg::t_dp_stat stat;
    logic              in_ready;

    assign i_in.ready = in_ready;

    tcr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (in_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    tcr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_img_w          (r_img_w),
        .i_img_h          (r_img_h),
        .i_command        (i_in.command),
        .i_ax             (i_in.vertex_a_x),
        .i_ay             (i_in.vertex_a_y),
        .i_bx             (i_in.vertex_b_x),
        .i_by             (i_in.vertex_b_y),
        .i_cx             (i_in.vertex_c_x),
        .i_cy             (i_in.vertex_c_y),
        .i_col            (i_in.read_column),
        .i_row            (i_in.read_row),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_pixel_lit      (o_out.pixel_lit),
        .o_pixels_covered (o_out.pixels_covered)
    );

    // busy right after taking a command word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command accepted on back-to-back cycles");

    // a lit read result carries no coverage count
    a_read_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pixel_lit) |-> (o_out.pixels_covered == '0))
        else $error("read result with nonzero count");

    // a new result only follows a busy period
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result appeared without a command in flight");

endmodule

`default_nettype wire
